[design/bpp_pkg.sv]
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types and constants for the boot packet parser with CRC-16 check.
// ----------------------------------------------------------------------------
package bpp_pkg;

    localparam int PAYLOAD_MAX_DEF = 128;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // frame layout
    localparam logic [15:0] POS_CMD       = 16'd0;
    localparam logic [15:0] POS_ADDR_LAST = 16'd4;
    localparam logic [15:0] POS_LEN       = 16'd5;
    localparam logic [15:0] POS_PAYLOAD   = 16'd6;
    localparam logic [15:0] POS_CRC_START = 16'd2;
    localparam logic [15:0] POS_SAT       = 16'hFFFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [6:0]  payload_index;
        logic        accepted;
        logic [7:0]  command_code;
        logic [31:0] target_address;
        logic [7:0]  declared_length;
    } result_t;

endpackage

[design/bpp_crc16_byte.sv]
// ----------------------------------------------------------------------------
// bpp_crc16_byte
// One-byte CRC-16/CCITT update, MSB first, no reflection.
// ----------------------------------------------------------------------------
module bpp_crc16_byte (
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import bpp_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

[design/bpp_parser.sv]
// ----------------------------------------------------------------------------
// bpp_parser
// Frame state, field capture, CRC tracking and per-beat result generation.
// ----------------------------------------------------------------------------
module bpp_parser #(
    parameter int PAYLOAD_MAX = bpp_pkg::PAYLOAD_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       data_byte,
    input  logic             frame_end,
    output logic             res_valid,
    output bpp_pkg::result_t res
);
    import bpp_pkg::*;

    localparam logic [7:0] PayloadMaxB = 8'(PAYLOAD_MAX);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  len_reg, len_next;
    logic        len_big_reg, len_big_next;

    logic [15:0] crc_fed;
    logic [15:0] crc_cur;
    logic [15:0] rel_pos;
    logic        in_payload;

    bpp_crc16_byte u_crc (
        .crc     (crc_reg),
        .data    (held1_reg),
        .crc_out (crc_fed)
    );

    // CRC runs two bytes behind so the trailing CRC field is never absorbed
    assign crc_cur    = (pos_reg >= POS_CRC_START) ? crc_fed : crc_reg;
    assign rel_pos    = pos_reg - POS_PAYLOAD;
    assign in_payload = (pos_reg >= POS_PAYLOAD) && !len_big_reg
                        && (rel_pos < {8'h00, len_reg});

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        len_big_next = len_big_reg;

        res_valid           = 1'b0;
        res.kind            = KIND_PAYLOAD;
        res.payload_byte    = 8'h00;
        res.payload_index   = 7'h00;
        res.accepted        = 1'b0;
        res.command_code    = cmd_reg;
        res.target_address  = addr_reg;
        res.declared_length = len_reg;

        if (in_fire)
        begin
            if (frame_end)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_VERDICT;
                if (pos_reg >= POS_PAYLOAD)
                begin
                    res.accepted = !len_big_reg && ({held0_reg, data_byte} == crc_cur);
                end
                else
                begin
                    res.command_code    = 8'h00;
                    res.target_address  = 32'h0;
                    res.declared_length = 8'h00;
                end
                pos_next     = 16'h0;
                crc_next     = CRC_INIT;
                held0_next   = 8'h00;
                held1_next   = 8'h00;
                cmd_next     = 8'h00;
                addr_next    = 32'h0;
                len_next     = 8'h00;
                len_big_next = 1'b0;
            end
            else
            begin
                crc_next   = crc_cur;
                held1_next = held0_reg;
                held0_next = data_byte;
                if (pos_reg != POS_SAT)
                begin
                    pos_next = pos_reg + 16'd1;
                end
                if (pos_reg == POS_CMD)
                begin
                    cmd_next = data_byte;
                end
                else if (pos_reg <= POS_ADDR_LAST)
                begin
                    addr_next = {addr_reg[23:0], data_byte};
                end
                else if (pos_reg == POS_LEN)
                begin
                    len_next     = data_byte;
                    len_big_next = data_byte > PayloadMaxB;
                end
                if (in_payload)
                begin
                    res_valid         = 1'b1;
                    res.payload_byte  = data_byte;
                    res.payload_index = rel_pos[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 16'h0;
            crc_reg     <= CRC_INIT;
            held0_reg   <= 8'h00;
            held1_reg   <= 8'h00;
            cmd_reg     <= 8'h00;
            addr_reg    <= 32'h0;
            len_reg     <= 8'h00;
            len_big_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            held0_reg   <= held0_next;
            held1_reg   <= held1_next;
            cmd_reg     <= cmd_next;
            addr_reg    <= addr_next;
            len_reg     <= len_next;
            len_big_reg <= len_big_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frame_end) |=> (pos_reg == 16'h0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after final beat");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !frame_end && pos_reg != POS_SAT)
        |=> (pos_reg == $past(pos_reg) + 16'd1))
        else $error("byte position did not advance");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(pos_reg))
        else $error("byte position moved without a beat");

    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD)
        |-> (!len_big_reg && pos_reg >= POS_PAYLOAD))
        else $error("payload result outside payload window");

endmodule

[design/bpp_out_stage.sv]
// ----------------------------------------------------------------------------
// bpp_out_stage
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module bpp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bpp_pkg::result_t res,
    input  logic             out_stall,
    output logic             out_valid,
    output logic             busy,
    output bpp_pkg::result_t res_q
);
    import bpp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // upstream holds only while a result sits here and is not taken
    assign busy      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign res_q     = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

[design/boot_packet_parser_crc16_unit.sv]
// ----------------------------------------------------------------------------
// boot_packet_parser_crc16_unit
// Streaming boot frame parser: field capture, payload emission, CRC verdict.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock while in_stall is low: the byte-wide CRC-16
// update and field capture sit between the frame state registers and the
// result register. A payload byte or verdict shows up at the output in the
// cycle after its input beat is accepted. Input stall
// rises only while a result is held in the output register and the consumer
// stalls it; beats that produce no result are still taken then only once the
// output register frees, so the sustained rate is one byte per clock when
// the consumer keeps up.
module boot_packet_parser_crc16_unit #(
    parameter int PAYLOAD_MAX = bpp_pkg::PAYLOAD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [6:0]  payload_index,
    output logic        accepted,
    output logic [7:0]  command_code,
    output logic [31:0] target_address,
    output logic [7:0]  declared_length
);
    import bpp_pkg::*;

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t res_q;

    assign in_fire = in_valid && !in_stall;

    bpp_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .res_valid (res_valid),
        .res       (res)
    );

    bpp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (in_stall),
        .res_q     (res_q)
    );

    assign result_kind     = res_q.kind;
    assign payload_byte    = res_q.payload_byte;
    assign payload_index   = res_q.payload_index;
    assign accepted        = res_q.accepted;
    assign command_code    = res_q.command_code;
    assign target_address  = res_q.target_address;
    assign declared_length = res_q.declared_length;

endmodule
